FILE: sv/assert_macros.svh
// Assertion macros shared by the buffer pool modules.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: sv/spbp_pkg.sv
// Shared types and constants of the sample buffer pool.
// No dependencies; imported by every module of the block.
package spbp_pkg;

  localparam int NumBuffersDef       = 16;
  localparam int RecordsPerBufferDef = 2;
  localparam int RecordBytesDef      = 12;
  // command queue depth, a power of two
  localparam int CmdDepth            = 4;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_WRITE_EMIT,
    OP_EMIT,
    OP_STATUS
  } cmd_op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_HOLD
  } back_state_e;

  typedef enum logic {
    CMD_SAMPLE    = 1'b0,
    CMD_SEND_DONE = 1'b1
  } in_cmd_e;

  typedef enum logic {
    REG_ENABLED = 1'b0,
    REG_NODE    = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_RECORD = 1'b1
  } out_kind_e;

  typedef struct packed {
    logic        [31:0] stamp;
    logic        [15:0] sensor;
    logic signed [31:0] reading;
  } rec_t;

  typedef struct packed {
    cmd_op_e     op;
    rec_t        rec;
    logic [31:0] drop;
  } cmd_t;

endpackage

FILE: sv/spbp_front.sv
// Front end: accepts items, keeps the free and send rings, the fill position
// and the drop counter, and issues at most one command per item. Uses spbp_pkg.
`include "assert_macros.svh"

module spbp_front #(
  parameter int NUM_BUFFERS        = spbp_pkg::NumBuffersDef,
  parameter int RECORDS_PER_BUFFER = spbp_pkg::RecordsPerBufferDef,
  parameter int RECORD_BYTES       = spbp_pkg::RecordBytesDef,
  localparam int SLOT_W            = $clog2(NUM_BUFFERS * RECORDS_PER_BUFFER)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic        [31:0] stamp_i,
  input  logic        [15:0] sensor_number_i,
  input  logic signed [31:0] reading_i,
  input  logic        [7:0]  bytes_done_i,
  input  logic               enabled_i,
  input  logic               full_i,
  output logic               push_o,
  output spbp_pkg::cmd_t     cmd_o,
  output logic [SLOT_W-1:0]  slot_o
);
  import spbp_pkg::*;

  localparam int BUF_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W  = $clog2(NUM_BUFFERS + 1);
  localparam int SUM_W  = BUF_W + 1;
  localparam int FILL_W = (RECORDS_PER_BUFFER > 1) ? $clog2(RECORDS_PER_BUFFER) : 1;
  localparam logic [BUF_W-1:0]  LAST_IDX   = BUF_W'(NUM_BUFFERS - 1);
  localparam logic [FILL_W-1:0] LAST_FILL  = FILL_W'(RECORDS_PER_BUFFER - 1);
  localparam logic [8:0]        SEND_BYTES = 9'(RECORD_BYTES * RECORDS_PER_BUFFER);
  localparam logic [SUM_W-1:0]  RING_LEN   = SUM_W'(NUM_BUFFERS);

  logic [BUF_W-1:0]  free_ring_q [NUM_BUFFERS];
  logic [BUF_W-1:0]  send_ring_q [NUM_BUFFERS];
  logic [BUF_W-1:0]  free_head_q, send_head_q;
  logic [CNT_W-1:0]  free_cnt_q, send_cnt_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [31:0]       drop_q, drop_d;
  logic [BUF_W-1:0]  send_front_q;

  logic              accept;
  logic [BUF_W-1:0]  free_front, free_next_head, send_next_head;
  logic [BUF_W-1:0]  free_tail, send_tail, send_next_id, emit_id;
  logic [SUM_W-1:0]  free_sum, send_sum;
  logic              free_pop, free_push, send_pop, send_push;
  logic              short_count;
  logic [SLOT_W-1:0] sample_slot, emit_slot;
  logic [SUM_W:0]    pool_total;
  logic              pool_ok;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  assign free_front     = free_ring_q[free_head_q];
  assign free_next_head = (free_head_q == LAST_IDX) ? '0 : BUF_W'(free_head_q + 1'b1);
  assign send_next_head = (send_head_q == LAST_IDX) ? '0 : BUF_W'(send_head_q + 1'b1);
  assign send_next_id   = send_ring_q[send_next_head];

  // ring tails: head plus count, folded once
  assign free_sum  = SUM_W'(free_head_q) + SUM_W'(free_cnt_q);
  assign send_sum  = SUM_W'(send_head_q) + SUM_W'(send_cnt_q);
  assign free_tail = (free_sum >= RING_LEN) ? BUF_W'(free_sum - RING_LEN) : BUF_W'(free_sum);
  assign send_tail = (send_sum >= RING_LEN) ? BUF_W'(send_sum - RING_LEN) : BUF_W'(send_sum);

  assign short_count = {1'b0, bytes_done_i} < SEND_BYTES;
  assign sample_slot = SLOT_W'(SLOT_W'(free_front) * SLOT_W'(RECORDS_PER_BUFFER)
                               + SLOT_W'(fill_q));
  assign emit_slot   = SLOT_W'(SLOT_W'(emit_id) * SLOT_W'(RECORDS_PER_BUFFER));

  always_comb begin
    push_o    = 1'b0;
    cmd_o.op  = OP_WRITE;
    drop_d    = drop_q;
    fill_d    = fill_q;
    free_pop  = 1'b0;
    free_push = 1'b0;
    send_pop  = 1'b0;
    send_push = 1'b0;
    emit_id   = send_front_q;
    if (accept) begin
      case (in_cmd_e'(command_i))
        CMD_SAMPLE: begin
          if (enabled_i) begin
            push_o = 1'b1;
            if (free_cnt_q == '0) begin
              drop_d   = drop_q + 32'd1;
              cmd_o.op = OP_STATUS;
            end else if (fill_q == LAST_FILL) begin
              // buffer full: hand it over to the send ring
              fill_d    = '0;
              free_pop  = 1'b1;
              send_push = 1'b1;
              cmd_o.op  = (send_cnt_q == '0) ? OP_WRITE_EMIT : OP_WRITE;
            end else begin
              fill_d = FILL_W'(fill_q + 1'b1);
            end
          end
        end
        CMD_SEND_DONE: begin
          if (send_cnt_q != '0) begin
            if (short_count) begin
              push_o   = 1'b1;
              cmd_o.op = OP_EMIT;
            end else begin
              send_pop  = 1'b1;
              free_push = 1'b1;
              if (send_cnt_q != CNT_W'(1)) begin
                push_o   = 1'b1;
                cmd_o.op = OP_EMIT;
                emit_id  = send_next_id;
              end
            end
          end
        end
        default: ;
      endcase
    end
    cmd_o.rec.stamp   = stamp_i;
    cmd_o.rec.sensor  = sensor_number_i;
    cmd_o.rec.reading = reading_i;
    cmd_o.drop        = drop_d;
  end

  assign slot_o = (cmd_o.op == OP_EMIT) ? emit_slot : sample_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        free_ring_q[i] <= BUF_W'(i);
      end
      free_head_q <= '0;
      free_cnt_q  <= CNT_W'(NUM_BUFFERS);
      send_head_q <= '0;
      send_cnt_q  <= '0;
      fill_q      <= '0;
      drop_q      <= '0;
    end else begin
      fill_q <= fill_d;
      drop_q <= drop_d;
      if (free_pop) begin
        free_head_q <= free_next_head;
        free_cnt_q  <= CNT_W'(free_cnt_q - 1'b1);
      end
      if (free_push) begin
        free_ring_q[free_tail] <= send_front_q;
        free_cnt_q             <= CNT_W'(free_cnt_q + 1'b1);
      end
      if (send_push) begin
        send_cnt_q <= CNT_W'(send_cnt_q + 1'b1);
      end
      if (send_pop) begin
        send_head_q <= send_next_head;
        send_cnt_q  <= CNT_W'(send_cnt_q - 1'b1);
      end
    end
  end

  // send ring contents and a copy of its front entry
  always_ff @(posedge clk_i) begin
    if (send_push) begin
      send_ring_q[send_tail] <= free_front;
      if (send_cnt_q == '0) begin
        send_front_q <= free_front;
      end
    end
    if (send_pop) begin
      send_front_q <= send_next_id;
    end
  end

  assign pool_total = (SUM_W + 1)'(free_cnt_q) + (SUM_W + 1)'(send_cnt_q);
  assign pool_ok    = (pool_total == (SUM_W + 1)'(NUM_BUFFERS));

  `ASSERT_AT(a_pool_conserved, clk_i, rst_ni, pool_ok, "buffer lost between rings")

endmodule

FILE: sv/spbp_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Uses spbp_pkg for the command type and depth.
`include "assert_macros.svh"

module spbp_cmd_fifo #(
  parameter int SLOT_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spbp_pkg::cmd_t    cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output spbp_pkg::cmd_t    cmd_o,
  output logic [SLOT_W-1:0] slot_o
);
  import spbp_pkg::*;

  localparam int PTR_W = $clog2(CmdDepth);
  localparam int CNT_W = $clog2(CmdDepth + 1);

  cmd_t              cmd_mem_q  [CmdDepth];
  logic [SLOT_W-1:0] slot_mem_q [CmdDepth];
  logic [PTR_W-1:0]  rd_ptr_q, wr_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(CmdDepth));
  assign cmd_o   = cmd_mem_q[rd_ptr_q];
  assign slot_o  = slot_mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CNT_W'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CNT_W'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_mem_q[wr_ptr_q]  <= cmd_i;
      slot_mem_q[wr_ptr_q] <= slot_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "command pushed into a full queue")

endmodule

FILE: sv/spbp_back.sv
// Back end: record store, command execution and the output register.
// Uses spbp_pkg for commands, records and the sequencer states.
`include "assert_macros.svh"

module spbp_back #(
  parameter int NUM_BUFFERS        = spbp_pkg::NumBuffersDef,
  parameter int RECORDS_PER_BUFFER = spbp_pkg::RecordsPerBufferDef,
  localparam int SLOT_W            = $clog2(NUM_BUFFERS * RECORDS_PER_BUFFER)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  spbp_pkg::cmd_t     cmd_i,
  input  logic [SLOT_W-1:0]  slot_i,
  output logic               cmd_pop_o,
  input  logic        [15:0] node_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic        [31:0] rec_stamp_o,
  output logic        [15:0] rec_node_o,
  output logic        [15:0] rec_sensor_o,
  output logic signed [31:0] rec_reading_o,
  output logic               last_record_o,
  output logic        [31:0] drop_total_o
);
  import spbp_pkg::*;

  localparam int SLOTS = NUM_BUFFERS * RECORDS_PER_BUFFER;
  localparam int REC_W = (RECORDS_PER_BUFFER > 1) ? $clog2(RECORDS_PER_BUFFER) : 1;
  localparam logic [REC_W-1:0]  LAST_REC = REC_W'(RECORDS_PER_BUFFER - 1);
  localparam logic [SLOT_W-1:0] LAST_OFS = SLOT_W'(RECORDS_PER_BUFFER - 1);

  rec_t               mem_q [SLOTS];
  rec_t               rd_q;
  back_state_e        state_q, state_d;
  logic [SLOT_W-1:0]  base_q, rd_addr;
  logic [REC_W-1:0]   rec_q;
  logic [31:0]        drop_q;
  logic               out_valid_q;
  out_kind_e          kind_q;
  logic        [31:0] stamp_q, drop_out_q;
  logic        [15:0] node_q, sensor_q;
  logic signed [31:0] reading_q;
  logic               last_q;

  logic mem_we, load_status, load_rec, out_done, rec_adv;

  assign rd_addr = SLOT_W'(base_q + SLOT_W'(rec_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_WRITE_EMIT, OP_EMIT: state_d = BK_READ;
            OP_STATUS:              state_d = BK_HOLD;
            default:                state_d = BK_IDLE;
          endcase
        end
      end
      BK_READ: state_d = BK_LOAD;
      BK_LOAD: state_d = BK_HOLD;
      BK_HOLD: begin
        if (!out_stall_i) begin
          state_d = (kind_q == KIND_RECORD && !last_q) ? BK_READ : BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o   = (state_q == BK_IDLE) && cmd_valid_i;
    mem_we      = cmd_pop_o && (cmd_i.op == OP_WRITE || cmd_i.op == OP_WRITE_EMIT);
    load_status = cmd_pop_o && (cmd_i.op == OP_STATUS);
    load_rec    = (state_q == BK_LOAD);
    out_done    = (state_q == BK_HOLD) && !out_stall_i;
    rec_adv     = out_done && (kind_q == KIND_RECORD) && !last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      rec_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_status || load_rec) begin
        out_valid_q <= 1'b1;
      end else if (out_done) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_pop_o) begin
        rec_q <= '0;
      end else if (rec_adv) begin
        rec_q <= REC_W'(rec_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      // a write that completes a buffer carries its last slot; step back to the first
      base_q <= (cmd_i.op == OP_WRITE_EMIT) ? SLOT_W'(slot_i - LAST_OFS) : slot_i;
      drop_q <= cmd_i.drop;
    end
    if (load_status) begin
      kind_q     <= KIND_STATUS;
      stamp_q    <= '0;
      node_q     <= '0;
      sensor_q   <= '0;
      reading_q  <= '0;
      last_q     <= 1'b0;
      drop_out_q <= cmd_i.drop;
    end else if (load_rec) begin
      kind_q     <= KIND_RECORD;
      stamp_q    <= rd_q.stamp;
      node_q     <= node_number_i;
      sensor_q   <= rd_q.sensor;
      reading_q  <= rd_q.reading;
      last_q     <= (rec_q == LAST_REC);
      drop_out_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[slot_i] <= cmd_i.rec;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign rec_stamp_o   = stamp_q;
  assign rec_node_o    = node_q;
  assign rec_sensor_o  = sensor_q;
  assign rec_reading_o = reading_q;
  assign last_record_o = last_q;
  assign drop_total_o  = drop_out_q;

  `ASSERT_NEVER(a_no_out_mid_read, clk_i, rst_ni, out_valid_q && (state_q == BK_READ || state_q == BK_LOAD), "output register loaded while a read is under way")
  `ASSERT_AT(a_pop_when_empty_out, clk_i, rst_ni, cmd_pop_o |-> !out_valid_q, "command taken while an item still waits")
  `ASSERT_AT(a_rec_in_range, clk_i, rst_ni, rec_q <= LAST_REC, "record index past end of buffer")

endmodule

FILE: sv/sample_packet_buffer_pool.sv
// Sample buffer pool: once a sample fills a buffer with the send ring empty, the back stores
// it, then moves each record through its read and load states into the output; a status
// item is loaded there when its command is taken. The front takes one item a cycle while the
// 4-entry command queue has room; the back takes a new command only while it is idle.
// Reset (rst_ni, async, active low) clears control state and config (enabled 0, node 1) and
// loads the free ring with buffers 0 upwards; the record store is not cleared.
module sample_packet_buffer_pool #(
  parameter int NUM_BUFFERS        = spbp_pkg::NumBuffersDef,
  parameter int RECORDS_PER_BUFFER = spbp_pkg::RecordsPerBufferDef,
  parameter int RECORD_BYTES       = spbp_pkg::RecordBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic        [15:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic        [31:0] stamp_i,
  input  logic        [15:0] sensor_number_i,
  input  logic signed [31:0] reading_i,
  input  logic        [7:0]  bytes_done_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic        [31:0] rec_stamp_o,
  output logic        [15:0] rec_node_o,
  output logic        [15:0] rec_sensor_o,
  output logic signed [31:0] rec_reading_o,
  output logic               last_record_o,
  output logic        [31:0] drop_total_o
);
  import spbp_pkg::*;

  localparam int SLOT_W = $clog2(NUM_BUFFERS * RECORDS_PER_BUFFER);

  logic              enabled_q;
  logic [15:0]       node_q;
  logic              push, full, fifo_valid, pop;
  cmd_t              front_cmd, fifo_cmd;
  logic [SLOT_W-1:0] front_slot, fifo_slot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      node_q    <= 16'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ENABLED: enabled_q <= cfg_data_i[0];
        REG_NODE:    node_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spbp_front #(
    .NUM_BUFFERS        (NUM_BUFFERS),
    .RECORDS_PER_BUFFER (RECORDS_PER_BUFFER),
    .RECORD_BYTES       (RECORD_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .stamp_i         (stamp_i),
    .sensor_number_i (sensor_number_i),
    .reading_i       (reading_i),
    .bytes_done_i    (bytes_done_i),
    .enabled_i       (enabled_q),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (front_cmd),
    .slot_o          (front_slot)
  );

  spbp_cmd_fifo #(
    .SLOT_W (SLOT_W)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .slot_i  (front_slot),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (fifo_cmd),
    .slot_o  (fifo_slot)
  );

  spbp_back #(
    .NUM_BUFFERS        (NUM_BUFFERS),
    .RECORDS_PER_BUFFER (RECORDS_PER_BUFFER)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (fifo_valid),
    .cmd_i         (fifo_cmd),
    .slot_i        (fifo_slot),
    .cmd_pop_o     (pop),
    .node_number_i (node_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .rec_stamp_o   (rec_stamp_o),
    .rec_node_o    (rec_node_o),
    .rec_sensor_o  (rec_sensor_o),
    .rec_reading_o (rec_reading_o),
    .last_record_o (last_record_o),
    .drop_total_o  (drop_total_o)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for sample_packet_buffer_pool: a table of directed items, then
// random sample/send-done traffic; items without typed results are predicted by a pool model.
// Needs spbp_pkg (sv/spbp_pkg.sv) and the block itself; nothing else.
module testbench;
  import spbp_pkg::*;

  localparam int ClkPeriod = 12;
  localparam int Rpb       = RecordsPerBufferDef;
  localparam int NumSlots  = NumBuffersDef * RecordsPerBufferDef;
  localparam int FullBytes = RecordBytesDef * RecordsPerBufferDef;
  localparam int SettleCycles = 20;

  typedef struct packed {
    in_cmd_e            cmd;
    logic        [31:0] stamp;
    logic        [15:0] sensor;
    logic signed [31:0] reading;
    logic        [7:0]  bytes;
  } sample_item_t;

  typedef struct packed {
    out_kind_e          kind;
    logic        [31:0] stamp;
    logic        [15:0] node;
    logic        [15:0] sensor;
    logic signed [31:0] reading;
    logic               last;
    logic        [31:0] drop;
  } pool_result_t;

  // directed row: either a register write or an item; typed_n < 0 means predicted
  typedef struct {
    bit           reg_write;
    cfg_reg_e     reg_idx;
    logic [15:0]  reg_val;
    sample_item_t item;
    int           typed_n;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic        [15:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic        [31:0] stamp_i = '0;
  logic        [15:0] sensor_number_i = '0;
  logic signed [31:0] reading_i = '0;
  logic        [7:0]  bytes_done_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               kind_o;
  logic        [31:0] rec_stamp_o;
  logic        [15:0] rec_node_o;
  logic        [15:0] rec_sensor_o;
  logic signed [31:0] rec_reading_o;
  logic               last_record_o;
  logic        [31:0] drop_total_o;

  sample_packet_buffer_pool u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .stamp_i        (stamp_i),
    .sensor_number_i(sensor_number_i),
    .reading_i      (reading_i),
    .bytes_done_i   (bytes_done_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .rec_stamp_o    (rec_stamp_o),
    .rec_node_o     (rec_node_o),
    .rec_sensor_o   (rec_sensor_o),
    .rec_reading_o  (rec_reading_o),
    .last_record_o  (last_record_o),
    .drop_total_o   (drop_total_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // pool model state
  logic        [31:0] stamp_mem   [NumSlots];
  logic        [15:0] sensor_mem  [NumSlots];
  logic signed [31:0] reading_mem [NumSlots];
  int unsigned        free_ids [$];
  int unsigned        send_ids [$];
  int unsigned        fill_pos;
  logic        [31:0] drops_seen;
  bit                 en_reg;
  logic        [15:0] node_reg;

  pool_result_t step_outputs [$];
  pool_result_t outputs_due [$];
  pool_result_t typed_outputs [$];
  dir_row_t     directed_rows [$];

  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int rcv_idle_pct = 0;
  int holdoff_left = 0;

  function automatic void queue_buffer_records(int unsigned buf_id);
    int unsigned slot;
    for (int k = 0; k < Rpb; k++) begin
      slot = buf_id * Rpb + k;
      step_outputs.push_back('{KIND_RECORD, stamp_mem[slot], node_reg, sensor_mem[slot],
                               reading_mem[slot], k == Rpb - 1, drops_seen});
    end
  endfunction

  function automatic void pool_step(sample_item_t it);
    int unsigned buf_id;
    int unsigned slot;
    bit was_empty;
    step_outputs.delete();
    if (it.cmd == CMD_SAMPLE) begin
      if (!en_reg) return;
      if (free_ids.size() == 0) begin
        drops_seen = drops_seen + 32'd1;
        step_outputs.push_back('{KIND_STATUS, '0, '0, '0, '0, 1'b0, drops_seen});
        return;
      end
      buf_id = free_ids[0];
      slot = buf_id * Rpb + fill_pos;
      stamp_mem[slot]   = it.stamp;
      sensor_mem[slot]  = it.sensor;
      reading_mem[slot] = it.reading;
      fill_pos++;
      if (fill_pos < Rpb) return;
      fill_pos = 0;
      void'(free_ids.pop_front());
      was_empty = (send_ids.size() == 0);
      send_ids.push_back(buf_id);
      if (was_empty) queue_buffer_records(buf_id);
    end else begin
      if (send_ids.size() == 0) return;
      if (it.bytes < FullBytes) begin
        queue_buffer_records(send_ids[0]);
        return;
      end
      free_ids.push_back(send_ids.pop_front());
      if (send_ids.size() != 0) queue_buffer_records(send_ids[0]);
    end
  endfunction

  function automatic sample_item_t random_item(int sample_pct);
    sample_item_t it;
    it.cmd     = ($urandom_range(99) < sample_pct) ? CMD_SAMPLE : CMD_SEND_DONE;
    it.stamp   = $urandom;
    it.sensor  = 16'($urandom);
    it.reading = $urandom;
    if ($urandom_range(9) == 0) it.reading = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    case ($urandom_range(3))
      0:       it.bytes = 8'(FullBytes - 1);
      1:       it.bytes = 8'($urandom_range(FullBytes - 1));
      2:       it.bytes = 8'($urandom_range(255, FullBytes));
      default: it.bytes = 8'(FullBytes);
    endcase
    return it;
  endfunction

  task automatic row_item(in_cmd_e cmd, logic [31:0] st, logic [15:0] sn, logic [31:0] rd,
                          logic [7:0] by, int typed_n);
    dir_row_t r;
    r.reg_write = 1'b0;
    r.reg_idx   = REG_ENABLED;
    r.reg_val   = '0;
    r.item      = '{cmd, st, sn, rd, by};
    r.typed_n   = typed_n;
    directed_rows.push_back(r);
  endtask

  task automatic row_reg(cfg_reg_e idx, logic [15:0] val);
    dir_row_t r;
    r.reg_write = 1'b1;
    r.reg_idx   = idx;
    r.reg_val   = val;
    r.item      = '0;
    r.typed_n   = 0;
    directed_rows.push_back(r);
  endtask

  task automatic row_expect(out_kind_e k, logic [31:0] st, logic [15:0] nd, logic [15:0] sn,
                            logic [31:0] rd, logic last, logic [31:0] dr);
    typed_outputs.push_back('{k, st, nd, sn, rd, last, dr});
  endtask

  // offer one item, hold it until taken, then book its results
  task automatic send_item(sample_item_t it, int typed_n);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= it.cmd;
    stamp_i         <= it.stamp;
    sensor_number_i <= it.sensor;
    reading_i       <= it.reading;
    bytes_done_i    <= it.bytes;
    do @(posedge clk_i); while (in_stall_o);
    pool_step(it);
    if (typed_n < 0) begin
      foreach (step_outputs[i]) outputs_due.push_back(step_outputs[i]);
    end else begin
      repeat (typed_n) outputs_due.push_back(typed_outputs.pop_front());
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk_i);
    // a lone sample write may still be in flight with nothing due
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ENABLED: en_reg = val[0];
      REG_NODE:    node_reg = val;
      default:     ;
    endcase
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pool_result_t got;
    pool_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{out_kind_e'(kind_o), rec_stamp_o, rec_node_o, rec_sensor_o, rec_reading_o,
              last_record_o, drop_total_o};
      if (outputs_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: kind=%0d st=%h nd=%h sn=%h rd=%h last=%0d drop=%0d",
                   got.kind, got.stamp, got.node, got.sensor, got.reading, got.last, got.drop);
      end else begin
        want = outputs_due.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected kind=%0d st=%h nd=%h sn=%h rd=%h last=%0d drop=%0d",
                     want.kind, want.stamp, want.node, want.sensor, want.reading, want.last,
                     want.drop);
            $display("  actual   kind=%0d st=%h nd=%h sn=%h rd=%h last=%0d drop=%0d",
                     got.kind, got.stamp, got.node, got.sensor, got.reading, got.last,
                     got.drop);
          end
        end
      end
    end
  end

  initial begin
    #(200_000 * ClkPeriod);
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      stamp_mem[i]   = '0;
      sensor_mem[i]  = '0;
      reading_mem[i] = '0;
    end
    for (int i = 0; i < NumBuffersDef; i++) free_ids.push_back(i);
    fill_pos   = 0;
    drops_seen = '0;
    en_reg     = 1'b0;
    node_reg   = 16'd1;

    // reset state: disabled, node 1
    row_item(CMD_SAMPLE, 32'h1234_5678, 16'hABCD, 32'h0000_0005, 8'h00, 0);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'hFF, 0);
    row_reg(REG_ENABLED, 16'h0001);
    row_item(CMD_SAMPLE, 32'h0000_0000, 16'h0000, 32'h8000_0000, 8'h00, 0);
    row_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 8'hFF, 2);
    row_expect(KIND_RECORD, 32'h0000_0000, 16'h0001, 16'h0000, 32'h8000_0000, 1'b0, 32'd0);
    row_expect(KIND_RECORD, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 32'd0);
    // one byte short: the same buffer again
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'(FullBytes - 1), 2);
    row_expect(KIND_RECORD, 32'h0000_0000, 16'h0001, 16'h0000, 32'h8000_0000, 1'b0, 32'd0);
    row_expect(KIND_RECORD, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 32'd0);
    row_reg(REG_NODE, 16'hFFFF);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'h00, 2);
    row_expect(KIND_RECORD, 32'h0000_0000, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0, 32'd0);
    row_expect(KIND_RECORD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, 32'd0);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'(FullBytes), 0);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'(FullBytes), 0);
    row_reg(REG_NODE, 16'h0000);
    row_item(CMD_SAMPLE, 32'hA5A5_0001, 16'h5A5A, 32'hFFFF_8000, 8'h00, 0);
    row_item(CMD_SAMPLE, 32'h5A5A_0002, 16'hA5A5, 32'h0000_8000, 8'h00, -1);
    // second full buffer queues behind the one on air
    row_item(CMD_SAMPLE, 32'h0F0F_0003, 16'h0F0F, 32'h0000_0001, 8'h00, 0);
    row_item(CMD_SAMPLE, 32'hF0F0_0004, 16'hF0F0, 32'hFFFF_FFFF, 8'h00, 0);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'hFF, -1);
    // send-done is honoured while disabled
    row_reg(REG_ENABLED, 16'h0000);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'h05, -1);
    row_item(CMD_SAMPLE, 32'h0000_1111, 16'h2222, 32'h0000_3333, 8'h00, 0);
    row_item(CMD_SEND_DONE, 32'h0, 16'h0, 32'h0, 8'(FullBytes), 0);

    sender_idle_pct = 35;
    rcv_idle_pct    = 54;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].reg_write) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed_n);
      end
    end

    // exhaust the pool with the receiver held off, so the block also backs up
    wait_idle();
    write_reg(REG_ENABLED, {15'($urandom), 1'b1});
    write_reg(REG_NODE, 16'($urandom));
    holdoff_left = 150;
    repeat (34) send_item(random_item(100), -1);

    // drain while disabled; samples here are dropped silently
    wait_idle();
    write_reg(REG_ENABLED, {15'($urandom), 1'b0});
    write_reg(REG_NODE, 16'h0000);
    repeat (10) send_item(random_item(20), -1);

    sender_idle_pct = 54;
    rcv_idle_pct    = 35;
    wait_idle();
    write_reg(REG_ENABLED, {15'($urandom), 1'b1});
    write_reg(REG_NODE, 16'hFFFF);
    repeat (25) send_item(random_item(60), -1);

    sender_idle_pct = 0;
    rcv_idle_pct    = 0;
    wait_idle();
    write_reg(REG_NODE, 16'($urandom));
    repeat (25) send_item(random_item(55), -1);

    wait_idle();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
